>>> rtl/radial_dead_zone_scaler_unit_macros.svh
// ----------------------------------------------------------------------------
// radial dead-zone scaler assertion macros
// shared property shorthands for the scaler top level
// ----------------------------------------------------------------------------
`ifndef RADIAL_DEAD_ZONE_SCALER_UNIT_MACROS_SVH
`define RADIAL_DEAD_ZONE_SCALER_UNIT_MACROS_SVH

// same-cycle implication
`define RDZS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RDZS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rdzs_pkg.sv
// ----------------------------------------------------------------------------
// rdzs_pkg
// shared constants and types of the radial dead-zone scaler
// ----------------------------------------------------------------------------
package rdzs_pkg;

    localparam int LEN_FRAC = 8;
    localparam int CFG_W    = 16;
    localparam int OUT_W    = 16;

    localparam logic [OUT_W-1:0] OUT_MAX_MAG    = 16'h7FFF;
    localparam logic [CFG_W-1:0] DEAD_ZONE_RST  = 16'd8000;
    localparam logic [CFG_W-1:0] FULL_SCALE_RST = 16'd30000;

    typedef enum logic {
        REG_DEAD_ZONE  = 1'b0,
        REG_FULL_SCALE = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

>>> rtl/rdzs_front.sv
// ----------------------------------------------------------------------------
// rdzs_front
// accepts sample pairs and splits them into sign and magnitude
// ----------------------------------------------------------------------------
module rdzs_front #(
    parameter int SB = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [SB-1:0]         stick_x,
    input  logic [SB-1:0]         stick_y,
    input  rdzs_pkg::qstat_t      q_stat,
    output logic                  push,
    output logic [2*SB+1:0]       push_data
);

    logic          fv_reg;
    logic          nx_reg;
    logic          ny_reg;
    logic [SB-1:0] ax_reg;
    logic [SB-1:0] ay_reg;
    logic [SB-1:0] ax_next;
    logic [SB-1:0] ay_next;

    always_comb
    begin
        ax_next   = stick_x[SB-1] ? (~stick_x + SB'(1)) : stick_x;
        ay_next   = stick_y[SB-1] ? (~stick_y + SB'(1)) : stick_y;
        in_ready  = !fv_reg || !q_stat.full;
        push      = fv_reg && !q_stat.full;
        push_data = {nx_reg, ny_reg, ax_reg, ay_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            fv_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            nx_reg <= stick_x[SB-1];
            ny_reg <= stick_y[SB-1];
            ax_reg <= ax_next;
            ay_reg <= ay_next;
        end
    end

endmodule

>>> rtl/rdzs_queue.sv
// ----------------------------------------------------------------------------
// rdzs_queue
// two-entry queue between the front and the arithmetic pipeline
// ----------------------------------------------------------------------------
module rdzs_queue #(
    parameter int W = 34
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [W-1:0]     din,
    input  logic             pop,
    output logic [W-1:0]     dout,
    output rdzs_pkg::qstat_t stat
);

    logic [W-1:0] mem [2];
    logic         wp_reg;
    logic         rp_reg;
    logic [1:0]   cnt_reg;
    logic [1:0]   cnt_next;

    always_comb
    begin
        stat.full  = (cnt_reg == 2'd2);
        stat.empty = (cnt_reg == 2'd0);
        dout       = mem[rp_reg];
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= din;
        end
    end

endmodule

>>> rtl/rdzs_back.sv
// ----------------------------------------------------------------------------
// rdzs_back
// length, dead-zone gain and rounded scaling pipeline with output register
// ----------------------------------------------------------------------------
module rdzs_back #(
    parameter int SB = 16,
    parameter int F  = 14
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rdzs_pkg::qstat_t             q_stat,
    input  logic [2*SB+1:0]              q_data,
    output logic                         pop,
    input  logic [rdzs_pkg::CFG_W-1:0]   dz_radius,
    input  logic [rdzs_pkg::CFG_W-1:0]   full_scale,
    input  logic [2*rdzs_pkg::CFG_W-1:0] dz_sq,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [rdzs_pkg::OUT_W-1:0]   out_x,
    output logic [rdzs_pkg::OUT_W-1:0]   out_y,
    output logic                         centered
);

    localparam int LF   = rdzs_pkg::LEN_FRAC;
    localparam int CFW  = rdzs_pkg::CFG_W;
    localparam int OW   = rdzs_pkg::OUT_W;
    localparam int SW   = 2 * SB;
    localparam int NW   = SW + 2 * LF;
    localparam int RW   = NW / 2;
    localparam int RMW  = RW + 2;
    localparam int QB   = F + 2;
    localparam int PW   = SB + RW;
    localparam int DW   = CFW + RW;
    localparam int NUMW = PW + F + 2;
    localparam int CW   = (NUMW > DW + 1 + QB) ? NUMW : DW + 1 + QB;
    localparam int CMW  = (SW > 2 * CFW) ? SW : 2 * CFW;
    localparam int FSW  = CFW + LF;
    localparam int LCW  = (RW > FSW) ? RW : FSW;
    localparam int MXW  = (QB > OW) ? QB : OW;

    logic adv;

    // squares stage
    logic          a_v_reg;
    logic          a_nx_reg;
    logic          a_ny_reg;
    logic [SB-1:0] a_ax_reg;
    logic [SB-1:0] a_ay_reg;
    logic [SW-1:0] a_sqx_reg;
    logic [SW-1:0] a_sqy_reg;

    // square root pipeline, entry 0 holds the radicand
    logic           st_v_reg    [RW+1];
    logic           st_cen_reg  [RW+1];
    logic           st_nx_reg   [RW+1];
    logic           st_ny_reg   [RW+1];
    logic [SB-1:0]  st_ax_reg   [RW+1];
    logic [SB-1:0]  st_ay_reg   [RW+1];
    logic [NW-1:0]  st_n_reg    [RW+1];
    logic [RMW-1:0] st_rem_reg  [RW+1];
    logic [RW-1:0]  st_root_reg [RW+1];

    logic [SW-1:0] s_next;

    // gain stage
    logic           c_v_reg;
    logic           c_cen_reg;
    logic           c_zr_reg;
    logic           c_full_reg;
    logic           c_nx_reg;
    logic           c_ny_reg;
    logic [SB-1:0]  c_ax_reg;
    logic [SB-1:0]  c_ay_reg;
    logic [RW-1:0]  c_lq_reg;
    logic [RW-1:0]  c_g_reg;
    logic [CFW-1:0] c_dif_reg;
    logic [RW-1:0]  lq;
    logic           full_next;

    // product stage
    logic          d_v_reg;
    logic          d_cen_reg;
    logic          d_zr_reg;
    logic          d_nx_reg;
    logic          d_ny_reg;
    logic [PW-1:0] d_px_reg;
    logic [PW-1:0] d_py_reg;
    logic [DW-1:0] d_den_reg;

    // divider pipeline, entry 0 holds numerators and divisor
    logic          dv_v_reg   [QB+1];
    logic          dv_cen_reg [QB+1];
    logic          dv_zr_reg  [QB+1];
    logic          dv_nx_reg  [QB+1];
    logic          dv_ny_reg  [QB+1];
    logic [CW-1:0] dv_rx_reg  [QB+1];
    logic [CW-1:0] dv_ry_reg  [QB+1];
    logic [CW-1:0] dv_d2_reg  [QB+1];
    logic [QB-1:0] dv_qx_reg  [QB+1];
    logic [QB-1:0] dv_qy_reg  [QB+1];

    // output register
    logic          ov_reg;
    logic [OW-1:0] ox_reg;
    logic [OW-1:0] oy_reg;
    logic          ocen_reg;
    logic [OW-1:0] ox_next;
    logic [OW-1:0] oy_next;
    logic [OW-1:0] magx;
    logic [OW-1:0] magy;

    always_comb
    begin
        adv       = !ov_reg || out_ready;
        pop       = adv && !q_stat.empty;
        out_valid = ov_reg;
        out_x     = ox_reg;
        out_y     = oy_reg;
        centered  = ocen_reg;
    end

    // squares
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_v_reg <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_nx_reg  <= q_data[2*SB+1];
            a_ny_reg  <= q_data[2*SB];
            a_ax_reg  <= q_data[2*SB-1:SB];
            a_ay_reg  <= q_data[SB-1:0];
            a_sqx_reg <= SW'(q_data[2*SB-1:SB]) * SW'(q_data[2*SB-1:SB]);
            a_sqy_reg <= SW'(q_data[SB-1:0]) * SW'(q_data[SB-1:0]);
        end
    end

    // dead-zone test and radicand
    assign s_next = a_sqx_reg + a_sqy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            st_v_reg[0] <= a_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_cen_reg[0]  <= CMW'(s_next) < CMW'(dz_sq);
            st_nx_reg[0]   <= a_nx_reg;
            st_ny_reg[0]   <= a_ny_reg;
            st_ax_reg[0]   <= a_ax_reg;
            st_ay_reg[0]   <= a_ay_reg;
            st_n_reg[0]    <= {s_next, (2*LF)'(0)};
            st_rem_reg[0]  <= '0;
            st_root_reg[0] <= '0;
        end
    end

    // one root bit per stage
    for (genvar k = 1; k <= RW; k++)
    begin : g_sqrt
        logic [RMW-1:0] rem_sh;
        logic [RMW-1:0] trial;
        logic           take;

        always_comb
        begin
            rem_sh = {st_rem_reg[k-1][RMW-3:0], st_n_reg[k-1][NW-1 -: 2]};
            trial  = {st_root_reg[k-1], 2'b01};
            take   = rem_sh >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                st_v_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                st_v_reg[k] <= st_v_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_cen_reg[k]  <= st_cen_reg[k-1];
                st_nx_reg[k]   <= st_nx_reg[k-1];
                st_ny_reg[k]   <= st_ny_reg[k-1];
                st_ax_reg[k]   <= st_ax_reg[k-1];
                st_ay_reg[k]   <= st_ay_reg[k-1];
                st_n_reg[k]    <= {st_n_reg[k-1][NW-3:0], 2'b00};
                st_rem_reg[k]  <= take ? (rem_sh - trial) : rem_sh;
                st_root_reg[k] <= {st_root_reg[k-1][RW-2:0], take};
            end
        end
    end

    // gain selection
    always_comb
    begin
        lq        = st_root_reg[RW];
        full_next = (full_scale <= dz_radius)
                 || (LCW'(lq) >= LCW'({full_scale, LF'(0)}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_v_reg <= st_v_reg[RW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_cen_reg  <= st_cen_reg[RW];
            c_zr_reg   <= (lq == '0);
            c_full_reg <= full_next;
            c_nx_reg   <= st_nx_reg[RW];
            c_ny_reg   <= st_ny_reg[RW];
            c_ax_reg   <= st_ax_reg[RW];
            c_ay_reg   <= st_ay_reg[RW];
            c_lq_reg   <= lq;
            c_g_reg    <= full_next ? RW'(1 << LF) : (lq - RW'({dz_radius, LF'(0)}));
            c_dif_reg  <= full_scale - dz_radius;
        end
    end

    // products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_v_reg <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_cen_reg <= c_cen_reg;
            d_zr_reg  <= c_zr_reg;
            d_nx_reg  <= c_nx_reg;
            d_ny_reg  <= c_ny_reg;
            d_px_reg  <= PW'(c_ax_reg) * PW'(c_g_reg);
            d_py_reg  <= PW'(c_ay_reg) * PW'(c_g_reg);
            d_den_reg <= c_full_reg ? DW'(c_lq_reg) : (DW'(c_dif_reg) * DW'(c_lq_reg));
        end
    end

    // rounding offset: numerator carries half a divisor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_v_reg[0] <= d_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_cen_reg[0] <= d_cen_reg;
            dv_zr_reg[0]  <= d_zr_reg;
            dv_nx_reg[0]  <= d_nx_reg;
            dv_ny_reg[0]  <= d_ny_reg;
            dv_rx_reg[0]  <= (CW'(d_px_reg) << (F + 1)) + CW'(d_den_reg);
            dv_ry_reg[0]  <= (CW'(d_py_reg) << (F + 1)) + CW'(d_den_reg);
            dv_d2_reg[0]  <= CW'(d_den_reg) << 1;
            dv_qx_reg[0]  <= '0;
            dv_qy_reg[0]  <= '0;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar j = 1; j <= QB; j++)
    begin : g_div
        logic [CW-1:0] dsh;
        logic          bx;
        logic          by;

        always_comb
        begin
            dsh = dv_d2_reg[j-1] << (QB - j);
            bx  = dv_rx_reg[j-1] >= dsh;
            by  = dv_ry_reg[j-1] >= dsh;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                dv_v_reg[j] <= dv_v_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_cen_reg[j] <= dv_cen_reg[j-1];
                dv_zr_reg[j]  <= dv_zr_reg[j-1];
                dv_nx_reg[j]  <= dv_nx_reg[j-1];
                dv_ny_reg[j]  <= dv_ny_reg[j-1];
                dv_d2_reg[j]  <= dv_d2_reg[j-1];
                dv_rx_reg[j]  <= bx ? (dv_rx_reg[j-1] - dsh) : dv_rx_reg[j-1];
                dv_ry_reg[j]  <= by ? (dv_ry_reg[j-1] - dsh) : dv_ry_reg[j-1];
                dv_qx_reg[j]  <= {dv_qx_reg[j-1][QB-2:0], bx};
                dv_qy_reg[j]  <= {dv_qy_reg[j-1][QB-2:0], by};
            end
        end
    end

    // saturate, apply sign, force zero when centered or zero length
    always_comb
    begin
        magx = (MXW'(dv_qx_reg[QB]) > MXW'(rdzs_pkg::OUT_MAX_MAG))
             ? rdzs_pkg::OUT_MAX_MAG : OW'(dv_qx_reg[QB]);
        magy = (MXW'(dv_qy_reg[QB]) > MXW'(rdzs_pkg::OUT_MAX_MAG))
             ? rdzs_pkg::OUT_MAX_MAG : OW'(dv_qy_reg[QB]);
        if (dv_cen_reg[QB] || dv_zr_reg[QB])
        begin
            ox_next = '0;
            oy_next = '0;
        end
        else
        begin
            ox_next = dv_nx_reg[QB] ? (~magx + OW'(1)) : magx;
            oy_next = dv_ny_reg[QB] ? (~magy + OW'(1)) : magy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            ov_reg <= dv_v_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ox_reg   <= ox_next;
            oy_reg   <= oy_next;
            ocen_reg <= dv_cen_reg[QB];
        end
    end

endmodule

>>> rtl/radial_dead_zone_scaler_unit.sv
// ----------------------------------------------------------------------------
// radial_dead_zone_scaler_unit
// radial dead-zone and full-scale scaling of a two-axis stick sample
//
//   channel   dir   handshake              content
//   s_axis    in    tvalid/tready          tdata: stick_x, stick_y
//   m_axis    out   tvalid/tready          tdata: out_x, out_y; tuser: centered
//   cfg       in    cfg_we                 cfg_index, cfg_wdata
//
// one request per cycle sustained unless the output stalls; a request passes
// the front register, queue, squares, radicand, (2*SAMPLE_BITS+16)/2 square-root
// stages, gain, products, rounding offset, (FRAC_BITS+2) divider stages and the
// output register; the root and the rounded divide each take one bit per stage
// a stalled output freezes the pipeline; input stalls once front and queue fill
// reset clears valid state and loads dead zone 8000, full scale 30000
// ----------------------------------------------------------------------------
`include "radial_dead_zone_scaler_unit_macros.svh"

module radial_dead_zone_scaler_unit #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 14,
    localparam int IN_W       = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [IN_W-1:0]            s_axis_tdata,  // stick_x, stick_y
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [2*rdzs_pkg::OUT_W-1:0] m_axis_tdata,  // out_x, out_y
    output logic [0:0]                 m_axis_tuser,  // centered
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_index,
    input  logic [rdzs_pkg::CFG_W-1:0] cfg_wdata
);

    localparam int SB = SAMPLE_BITS;
    localparam int QW = 2 * SB + 2;
    localparam int CFW = rdzs_pkg::CFG_W;

    logic [CFW-1:0]   dz_reg;
    logic [CFW-1:0]   fs_reg;
    logic [2*CFW-1:0] dzsq_reg;

    rdzs_pkg::qstat_t q_stat;
    logic             q_push;
    logic             q_pop;
    logic [QW-1:0]    q_din;
    logic [QW-1:0]    q_dout;

    logic [rdzs_pkg::OUT_W-1:0] out_x;
    logic [rdzs_pkg::OUT_W-1:0] out_y;
    logic                       centered;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg   <= rdzs_pkg::DEAD_ZONE_RST;
            fs_reg   <= rdzs_pkg::FULL_SCALE_RST;
            dzsq_reg <= (2*CFW)'(rdzs_pkg::DEAD_ZONE_RST) * (2*CFW)'(rdzs_pkg::DEAD_ZONE_RST);
        end
        else if (cfg_we)
        begin
            case (rdzs_pkg::cfg_idx_t'(cfg_index))
                rdzs_pkg::REG_DEAD_ZONE:
                begin
                    dz_reg   <= cfg_wdata;
                    dzsq_reg <= (2*CFW)'(cfg_wdata) * (2*CFW)'(cfg_wdata);
                end
                rdzs_pkg::REG_FULL_SCALE:
                begin
                    fs_reg <= cfg_wdata;
                end
                default:
                begin
                    fs_reg <= fs_reg;
                end
            endcase
        end
    end

    rdzs_front #(
        .SB (SB)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .stick_x   (s_axis_tdata[SB-1:0]),
        .stick_y   (s_axis_tdata[2*SB-1:SB]),
        .q_stat    (q_stat),
        .push      (q_push),
        .push_data (q_din)
    );

    rdzs_queue #(
        .W (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .stat  (q_stat)
    );

    rdzs_back #(
        .SB (SB),
        .F  (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .q_data     (q_dout),
        .pop        (q_pop),
        .dz_radius  (dz_reg),
        .full_scale (fs_reg),
        .dz_sq      (dzsq_reg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_x      (out_x),
        .out_y      (out_y),
        .centered   (centered)
    );

    assign m_axis_tdata = {out_y, out_x};
    assign m_axis_tuser = centered;

    `RDZS_ASSERT_IMP(a_centered_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0, "centered request with nonzero outputs")
    `RDZS_ASSERT_IMP(a_no_min_x, m_axis_tvalid, m_axis_tdata[15:0] != 16'h8000, "out_x beyond saturation")
    `RDZS_ASSERT_IMP(a_push_space, q_push, !q_stat.full, "push into full queue")
    `RDZS_ASSERT_NXT(a_full_drain, q_stat.full, !q_stat.empty, "queue emptied too fast")

endmodule

>>> sim/rdzs_scoreboard.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rdzs_scoreboard
// watches the sample and result streams of the radial dead-zone scaler,
// predicts each scaled result from the accepted sample and the current
// dead-zone and full-scale settings, and compares it field by field
// ----------------------------------------------------------------------------
module rdzs_scoreboard (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    input  logic [31:0]                s_axis_tdata,
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic [31:0]                m_axis_tdata,
    input  logic [0:0]                 m_axis_tuser,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_index,
    input  logic [rdzs_pkg::CFG_W-1:0] cfg_wdata,
    output int                         fail_count,
    output int                         pending
);

    localparam int FRAC_BITS_TB = 14;

    typedef struct packed {
        logic [15:0] out_x;
        logic [15:0] out_y;
        logic        centered;
    } scaled_t;

    scaled_t     scaled_q[$];
    logic [15:0] dz_reg;
    logic [15:0] fs_reg;

    function automatic logic [63:0] root_floor(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] apply_sign(logic [15:0] a, logic [63:0] g,
                                               logic [63:0] den, logic neg);
        logic [127:0] num;
        logic [127:0] q;
        logic [15:0]  mag;
        num = ({112'd0, a} * {64'd0, g}) << (FRAC_BITS_TB + 1);
        num = num + {64'd0, den};
        q = num / ({64'd0, den} << 1);
        mag = (q > 128'd32767) ? 16'h7FFF : q[15:0];
        return neg ? -mag : mag;
    endfunction

    function automatic scaled_t scale_sample(logic signed [15:0] x,
                                             logic signed [15:0] y);
        scaled_t     r;
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] s;
        logic [63:0] lq;
        logic [63:0] g;
        logic [63:0] den;
        r = '0;
        ax = (x < 0) ? -64'(x) : 64'(x);
        ay = (y < 0) ? -64'(y) : 64'(y);
        s = ax * ax + ay * ay;
        if (s < 64'(dz_reg) * 64'(dz_reg))
        begin
            r.centered = 1'b1;
            return r;
        end
        lq = root_floor(s << (2 * rdzs_pkg::LEN_FRAC));
        if (lq == 0)
            return r;
        if (fs_reg <= dz_reg || lq >= (64'(fs_reg) << rdzs_pkg::LEN_FRAC))
        begin
            g = 64'd1 << rdzs_pkg::LEN_FRAC;
            den = lq;
        end
        else
        begin
            g = lq - (64'(dz_reg) << rdzs_pkg::LEN_FRAC);
            den = 64'(fs_reg - dz_reg) * lq;
        end
        r.out_x = apply_sign(ax[15:0], g, den, x < 0);
        r.out_y = apply_sign(ay[15:0], g, den, y < 0);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        scaled_t want;
        scaled_t got;
        if (!rst_n)
        begin
            dz_reg     <= rdzs_pkg::DEAD_ZONE_RST;
            fs_reg     <= rdzs_pkg::FULL_SCALE_RST;
            fail_count <= 0;
            pending    <= 0;
            scaled_q.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                scaled_q.insert(scaled_q.size(),
                                scale_sample(s_axis_tdata[15:0], s_axis_tdata[31:16]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser[0]};
                if (scaled_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result %h", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = scaled_q.pop_front();
                    if (want !== got)
                    begin
                        if (fail_count < 10)
                            $display({"mismatch x exp %0d got %0d, y exp %0d got %0d,",
                                      " c exp %b got %b"},
                                     $signed(want.out_x), $signed(got.out_x),
                                     $signed(want.out_y), $signed(got.out_y),
                                     want.centered, got.centered);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= scaled_q.size();
            if (cfg_we)
            begin
                if (rdzs_pkg::cfg_idx_t'(cfg_index) == rdzs_pkg::REG_DEAD_ZONE)
                    dz_reg <= cfg_wdata;
                else
                    fs_reg <= cfg_wdata;
            end
        end
    end

endmodule

>>> sim/tb_radial_dead_zone_scaler_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radial_dead_zone_scaler_unit
// drives stick samples in bursts through several dead-zone and full-scale
// settings with a randomly stalling receiver; the scoreboard checks results
// ----------------------------------------------------------------------------
module tb_radial_dead_zone_scaler_unit;

    logic                       clk;
    logic                       rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [31:0]                s_axis_tdata;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [31:0]                m_axis_tdata;
    logic [0:0]                 m_axis_tuser;
    logic                       cfg_we;
    logic [0:0]                 cfg_index;
    logic [rdzs_pkg::CFG_W-1:0] cfg_wdata;
    int                         fail_count;
    int                         pending;
    int                         cycle_count;
    int                         hold_off;
    logic                       done;

    radial_dead_zone_scaler_unit dut (.*);

    rdzs_scoreboard scoreboard (.*);

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        hold_off      = 0;
        done          = 1'b0;
        rst_n         = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // receiver stall pattern, with a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_off      <= hold_off - 1;
        end
        else if (cycle_count % 3000 < 800)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end
    initial cycle_count = 0;

    task automatic send_sample(logic [15:0] x, logic [15:0] y);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic pause_sender();
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    task automatic write_reg(rdzs_pkg::cfg_idx_t idx, logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic random_samples(int count, int radius);
        int   n;
        int   burst;
        logic [15:0] x;
        logic [15:0] y;
        n = 0;
        while (n < count)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && n < count)
            begin
                if (radius == 0)
                begin
                    x = 16'($urandom);
                    y = 16'($urandom);
                end
                else
                begin
                    x = 16'(int'($urandom_range(0, 2 * radius)) - radius);
                    y = 16'(int'($urandom_range(0, 2 * radius)) - radius);
                end
                send_sample(x, y);
                burst--;
                n++;
            end
            if ($urandom_range(0, 2) != 0)
                pause_sender();
        end
    endtask

    logic [15:0] dz_set[6] = '{16'd8000, 16'd0, 16'd65535, 16'd1000, 16'd20000, 16'd3000};
    logic [15:0] fs_set[6] = '{16'd30000, 16'd0, 16'd65535, 16'd40000, 16'd10000, 16'd3000};

    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        // extremes and special cases at reset settings
        send_sample(16'h0000, 16'h0000);
        send_sample(16'h8000, 16'h8000);
        send_sample(16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h0000);
        send_sample(16'h0000, 16'h7FFF);
        send_sample(16'd7999, 16'd0);
        send_sample(16'd8000, 16'd0);
        send_sample(16'd0, -16'sd8000);
        send_sample(16'd30000, 16'd0);
        send_sample(16'd15000, -16'sd15000);
        send_sample(16'hFFFF, 16'h0001);
        drain();
        write_reg(rdzs_pkg::REG_DEAD_ZONE, 16'd0);
        write_reg(rdzs_pkg::REG_FULL_SCALE, 16'd0);
        send_sample(16'h0000, 16'h0000);
        send_sample(16'h0001, 16'hFFFF);
        send_sample(16'h8000, 16'h7FFF);
        send_sample(16'h5555, 16'hAAAA);
        drain();
        // long receiver hold-off while the sender keeps offering
        hold_off = 300;
        random_samples(80, 0);
        drain();
        for (int i = 0; i < 6; i++)
        begin
            write_reg(rdzs_pkg::REG_DEAD_ZONE, dz_set[i]);
            write_reg(rdzs_pkg::REG_FULL_SCALE, fs_set[i]);
            random_samples(170, 0);
            random_samples(140, 20 + dz_set[i] / 2 + fs_set[i] / 2 > 32767 ?
                           32767 : 20 + dz_set[i] / 2 + fs_set[i] / 2);
            drain();
        end
        done = 1'b1;
    end

    initial
    begin
        wait (done === 1'b1);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
